@@ design/htbe_pkg.sv @@
package htbe_pkg;

  localparam int unsigned WIN_DEPTH = 9;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;

  localparam logic [LEN_W-1:0] BODY_MAX = 13'd4095;

  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  // entry 0 is the first byte of each pattern
  localparam win_t PAT_OPEN   = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "-", "-", "!"};
  localparam win_t PAT_CLOSE  = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ">", "-", "-"};
  localparam win_t PAT_SCRIPT = {8'h00, 8'h00, 8'h00, "t", "p", "i", "r", "c", "s"};
  localparam win_t PAT_END    = {">", "t", "p", "i", "r", "c", "s", "/", "<"};

  localparam logic [CNT_W-1:0] OPEN_LEN   = 4'd3;
  localparam logic [CNT_W-1:0] CLOSE_LEN  = 4'd3;
  localparam logic [CNT_W-1:0] SCRIPT_LEN = 4'd6;
  localparam logic [CNT_W-1:0] END_LEN    = 4'd9;

  typedef enum logic [5:0] {
    MODE_OUT     = 6'b000001,
    MODE_LT      = 6'b000010,
    MODE_COMMENT = 6'b000100,
    MODE_SCRIPT  = 6'b001000,
    MODE_TAG     = 6'b010000,
    MODE_TRUNC   = 6'b100000
  } mode_e;

  typedef enum logic [1:0] {
    MATCH_NO   = 2'd0,
    MATCH_YES  = 2'd1,
    MATCH_MORE = 2'd2
  } match_e;

  typedef struct packed {
    logic [7:0] text;
    logic       fin;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_push_t;

  typedef struct packed {
    logic  valid;
    logic  full;
    item_t item;
  } q_stat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       has;
    logic       last;
    logic       trunc;
  } res_t;

  function automatic match_e match_pat(win_t w, logic [CNT_W-1:0] cnt, logic fin,
                                       win_t pat, logic [CNT_W-1:0] len);
    logic   mism;
    match_e r;
    mism = 1'b0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if ((CNT_W'(k) < len) && (CNT_W'(k) < cnt) && (w[k] != pat[k])) begin
        mism = 1'b1;
      end
    end
    if (mism) begin
      r = MATCH_NO;
    end else if (cnt >= len) begin
      r = MATCH_YES;
    end else if (fin) begin
      r = MATCH_NO;
    end else begin
      r = MATCH_MORE;
    end
    return r;
  endfunction

endpackage

@@ design/htbe_front.sv @@
module htbe_front import htbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       q_full_i,
  output q_push_t    push_o
);

  logic       tag_q, tag_d;
  logic       quote_q, quote_d;
  logic [7:0] byte_lo;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    byte_lo = text_byte_i;
    tag_d   = tag_q;
    quote_d = quote_q;
    if (tag_q) begin
      if (quote_q) begin
        if (text_byte_i == CH_QUOTE) quote_d = 1'b0;
      end else if (text_byte_i == CH_GT) begin
        tag_d = 1'b0;
      end else if (text_byte_i == CH_QUOTE) begin
        quote_d = 1'b1;
      end else if (text_byte_i inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
        byte_lo = text_byte_i + CASE_OFFSET;
      end else if (text_byte_i == CH_NL) begin
        byte_lo = CH_SPACE;
      end
    end else if (text_byte_i == CH_LT) begin
      tag_d = 1'b1;
    end
    if (end_of_text_i) begin
      tag_d   = 1'b0;
      quote_d = 1'b0;
    end
  end

  assign push_o.push      = accept;
  assign push_o.item.text = byte_lo;
  assign push_o.item.fin  = end_of_text_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= 1'b0;
      quote_q <= 1'b0;
    end else if (accept) begin
      tag_q   <= tag_d;
      quote_q <= quote_d;
    end
  end

endmodule

@@ design/htbe_fifo.sv @@
module htbe_fifo import htbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  input  logic    pop_i,
  output q_stat_t stat_o
);

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               full, do_push, do_pop;

  assign full     = (cnt_q == QCNT_W'(QDEPTH));
  assign do_push  = push_i.push && !full;
  assign do_pop   = pop_i && (cnt_q != '0);

  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = full;
  assign stat_o.item  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPTR_W'(1);
      if (do_pop)  rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

@@ design/htbe_back.sv @@
module htbe_back import htbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_stat_t stat_i,
  output logic    pop_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output res_t    res_o
);

  mode_e             mode_q, mode_d;
  logic              skip_q, skip_d;
  logic [LEN_W-1:0]  len_q, len_d, len_inc;
  logic              kind_q, kind_d;
  logic              fin_q, fin_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_sh, consume;
  win_t              win_q, win_d;
  logic              out_valid_q;
  res_t              out_q, res;
  logic              emit, step, act, pull, slot_free;
  match_e            m_open, m_close, m_script, m_end;

  assign slot_free = !out_valid_q || out_ready_i;
  assign len_inc   = len_q + LEN_W'(1);

  assign m_open   = match_pat(win_q, cnt_q, fin_q, PAT_OPEN, OPEN_LEN);
  assign m_close  = match_pat(win_q, cnt_q, fin_q, PAT_CLOSE, CLOSE_LEN);
  assign m_script = match_pat(win_q, cnt_q, fin_q, PAT_SCRIPT, SCRIPT_LEN);
  assign m_end    = match_pat(win_q, cnt_q, fin_q, PAT_END, END_LEN);

  always_comb begin
    mode_d  = mode_q;
    skip_d  = skip_q;
    len_d   = len_q;
    kind_d  = kind_q;
    fin_d   = fin_q;
    consume = '0;
    emit    = 1'b0;
    step    = 1'b0;
    res     = '0;

    if (mode_q == MODE_TRUNC) begin
      emit      = 1'b1;
      res.kind  = kind_q;
      res.last  = 1'b1;
      res.trunc = 1'b1;
      mode_d    = MODE_OUT;
      skip_d    = 1'b1;
    end else if (cnt_q == '0) begin
      // document done once its last byte has been scanned
      if (fin_q) begin
        if (mode_q == MODE_SCRIPT || mode_q == MODE_TAG || mode_q == MODE_LT) begin
          emit     = 1'b1;
          res.kind = (mode_q == MODE_SCRIPT);
          res.last = 1'b1;
        end
        mode_d = MODE_OUT;
        skip_d = 1'b0;
        len_d  = '0;
        fin_d  = 1'b0;
      end
    end else begin
      case (mode_q)
        MODE_OUT: begin
          consume = CNT_W'(1);
          if (skip_q) begin
            skip_d = 1'b0;
          end else if (win_q[0] == CH_LT) begin
            mode_d = MODE_LT;
          end
        end
        MODE_LT: begin
          if (m_open == MATCH_YES) begin
            consume = CNT_W'(1);
            mode_d  = MODE_COMMENT;
          end else if (m_open == MATCH_NO && m_script != MATCH_MORE) begin
            len_d = '0;
            if (m_script == MATCH_YES) begin
              consume = CNT_W'(1);
              mode_d  = MODE_SCRIPT;
              kind_d  = 1'b1;
            end else begin
              mode_d = MODE_TAG;
              kind_d = 1'b0;
            end
          end
        end
        MODE_COMMENT: begin
          if (m_close == MATCH_YES) begin
            consume = CLOSE_LEN;
            skip_d  = 1'b1;
            mode_d  = MODE_OUT;
          end else if (m_close == MATCH_NO) begin
            consume = CNT_W'(1);
          end
        end
        MODE_SCRIPT: begin
          if (m_end == MATCH_YES) begin
            consume  = END_LEN;
            emit     = 1'b1;
            res.kind = 1'b1;
            res.last = 1'b1;
            skip_d   = 1'b1;
            mode_d   = MODE_OUT;
          end else if (m_end == MATCH_NO) begin
            step = 1'b1;
          end
        end
        MODE_TAG: begin
          if (win_q[0] == CH_GT) begin
            consume  = CNT_W'(1);
            emit     = 1'b1;
            res.last = 1'b1;
            mode_d   = MODE_OUT;
          end else begin
            step = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (step) begin
      consume  = CNT_W'(1);
      emit     = 1'b1;
      res.kind = kind_q;
      res.data = win_q[0];
      res.has  = 1'b1;
      len_d    = len_inc;
      if (len_inc >= BODY_MAX) mode_d = MODE_TRUNC;
    end

    act = !emit || slot_free;
    if (!act) begin
      mode_d  = mode_q;
      skip_d  = skip_q;
      len_d   = len_q;
      kind_d  = kind_q;
      fin_d   = fin_q;
      consume = '0;
    end

    cnt_sh = cnt_q - consume;
    pull   = stat_i.valid && !fin_d && (cnt_sh < CNT_W'(WIN_DEPTH));
    win_d  = win_t'(win_q >> {consume, 3'b000});
    if (pull) begin
      win_d[cnt_sh] = stat_i.item.text;
      if (stat_i.item.fin) fin_d = 1'b1;
    end
    cnt_d = cnt_sh + CNT_W'(pull);
  end

  assign pop_o       = pull;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (act && emit) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OUT;
      skip_q      <= 1'b0;
      len_q       <= '0;
      kind_q      <= 1'b0;
      fin_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      skip_q <= skip_d;
      len_q  <= len_d;
      kind_q <= kind_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
      if (act && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ design/html_tag_body_extractor_top.sv @@
// HTML tag body extractor.
// Input channel (in_valid_i/in_ready_o): one text byte per beat, end_of_text_i
// set on the last byte of a document. Inside tags, outside quotes, capitals are
// lowered and newlines turn to spaces on entry; all go via a 4-entry queue.
// Output channel (out_valid_o/out_ready_i): one beat per body byte, then one
// end marker per body (has_byte 0, body_last 1, truncated on length cap).
// Scanner: one step per cycle while no result is held in the output register,
// out of a 9-byte lookahead window; an ordinary tag opening, the end of a
// document and a truncated body each take a step that consumes no byte.
// Path: an accepted byte is registered in the queue, then in the window, and
// its result in out_q; bytes awaiting a closing pattern stay in the window.
// Stall: a result waits in the output register; the scanner stops at its next
// result while one is held, and once the queue fills in_ready_o drops.
// Reset: empties queue, window and output, scanner returns to outside-of-tag.
// After a document's last byte, tag, quote, mode and length state return to reset.
module html_tag_body_extractor_top import htbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       body_kind_o,
  output logic [7:0] body_byte_o,
  output logic       has_byte_o,
  output logic       body_last_o,
  output logic       truncated_o
);

  q_push_t q_push;
  q_stat_t q_stat;
  logic    q_pop;
  res_t    res;

  htbe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_stat.full),
    .push_o        (q_push)
  );

  htbe_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pop_i  (q_pop),
    .stat_o (q_stat)
  );

  htbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (q_stat),
    .pop_o       (q_pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign body_kind_o = res.kind;
  assign body_byte_o = res.data;
  assign has_byte_o  = res.has;
  assign body_last_o = res.last;
  assign truncated_o = res.trunc;

  a_trunc_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && truncated_o) |-> (body_last_o && !has_byte_o))
    else $error("truncated flag outside an end marker");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !q_push.push)
    else $error("push into full queue");

  a_beat_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> q_stat.valid)
    else $error("accepted beat missing from queue");

endmodule
